@@ rtl/core/aa2rm_pkg.sv @@
// Shared types, constants and helper functions for the axis-angle to rotation matrix core.
// Used by the CORDIC cell, the matrix stage and the top level. No dependencies.
package aa2rm_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
    localparam int SHW  = 5;

    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [32:0] Q30_GAIN    = 33'sd652032874;

    typedef logic signed [32:0] t_q30;
    typedef logic signed [15:0] t_q14;
    typedef logic signed [18:0] t_trig;

    typedef struct packed {
        t_q30 x;
        t_q30 y;
        t_q30 z;
        logic neg;
        t_q14 ax;
        t_q14 ay;
        t_q14 az;
    } t_cstate;

    function automatic t_q30 atan_q30(input int i);
        t_q30 r;
        case (i)
            0:  r = 33'sd843314857;
            1:  r = 33'sd497837829;
            2:  r = 33'sd263043837;
            3:  r = 33'sd133525159;
            4:  r = 33'sd67021687;
            5:  r = 33'sd33543516;
            6:  r = 33'sd16775851;
            7:  r = 33'sd8388437;
            8:  r = 33'sd4194283;
            9:  r = 33'sd2097149;
            10: r = 33'sd1048576;
            11: r = 33'sd524288;
            12: r = 33'sd262144;
            13: r = 33'sd131072;
            14: r = 33'sd65536;
            15: r = 33'sd32768;
            16: r = 33'sd16384;
            17: r = 33'sd8192;
            18: r = 33'sd4096;
            19: r = 33'sd2048;
            20: r = 33'sd1024;
            21: r = 33'sd512;
            22: r = 33'sd256;
            default: r = 33'sd128;
        endcase
        return r;
    endfunction

    function automatic t_q14 round_sat(input logic signed [55:0] a);
        logic signed [55:0] s;
        logic signed [25:0] r;
        s = a + 56'sd536870912;
        r = s[55:30];
        if (r > 26'sd16384) begin
            return 16'sd16384;
        end else if (r < -26'sd16384) begin
            return -16'sd16384;
        end
        return r[15:0];
    endfunction

endpackage

@@ rtl/core/aa2rm_cordic_cell.sv @@
// One rotation-mode CORDIC cell: a micro-rotation and its output register.
// Depends on aa2rm_pkg for the cell state type.
module aa2rm_cordic_cell
    import aa2rm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [SHW-1:0]   i_shift,
    input  t_q30             i_atan,
    input  logic             i_valid,
    input  t_cstate          i_st,
    output logic             o_valid,
    output t_cstate          o_st
);

    t_q30    dx;
    t_q30    dy;
    t_cstate n_st;
    t_cstate r_st;
    logic    r_valid;

    always_comb begin
        dx   = i_st.y >>> i_shift;
        dy   = i_st.x >>> i_shift;
        n_st = i_st;
        if (!i_st.z[32]) begin
            n_st.x = i_st.x - dx;
            n_st.y = i_st.y + dy;
            n_st.z = i_st.z - i_atan;
        end else begin
            n_st.x = i_st.x + dx;
            n_st.y = i_st.y - dy;
            n_st.z = i_st.z + i_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_valid;
    assign o_st    = r_st;

endmodule

@@ rtl/core/aa2rm_dcm.sv @@
// Matrix stage: rounds cos and sin, forms axis products and sums the nine entries.
// Three register stages; depends on aa2rm_pkg.
module aa2rm_dcm
    import aa2rm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_cstate i_st,
    output logic    o_valid,
    output t_q14    o_c00,
    output t_q14    o_c01,
    output t_q14    o_c02,
    output t_q14    o_c10,
    output t_q14    o_c11,
    output t_q14    o_c12,
    output t_q14    o_c20,
    output t_q14    o_c21,
    output t_q14    o_c22
);

    t_q30 xn;
    t_q30 yn;
    t_q30 xr;
    t_q30 yr;
    t_trig c;
    t_trig s;

    logic [2:0] r_valid;
    logic signed [31:0] r_p00, r_p01, r_p02, r_p11, r_p12, r_p22;
    logic signed [34:0] r_es0, r_es1, r_es2;
    t_trig r_c1;
    logic signed [19:0] r_sg;

    logic signed [50:0] r_t00, r_t01, r_t02, r_t11, r_t12, r_t22;
    logic signed [34:0] r_f0, r_f1, r_f2;
    t_trig r_c2;

    logic signed [55:0] dg, q0, q1, q2;
    t_q14 r_c00, r_c01, r_c02, r_c10, r_c11, r_c12, r_c20, r_c21, r_c22;

    always_comb begin
        xn = i_st.neg ? -i_st.x : i_st.x;
        yn = i_st.neg ? -i_st.y : i_st.y;
        xr = xn + 33'sd8192;
        yr = yn + 33'sd8192;
        c  = xr[32:14];
        s  = yr[32:14];
        dg = 56'(r_c2) <<< 28;
        q0 = 56'(r_f0) <<< 14;
        q1 = 56'(r_f1) <<< 14;
        q2 = 56'(r_f2) <<< 14;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
        if (i_en) begin
            r_p00 <= i_st.ax * i_st.ax;
            r_p01 <= i_st.ax * i_st.ay;
            r_p02 <= i_st.ax * i_st.az;
            r_p11 <= i_st.ay * i_st.ay;
            r_p12 <= i_st.ay * i_st.az;
            r_p22 <= i_st.az * i_st.az;
            r_es0 <= 35'(i_st.ax) * 35'(s);
            r_es1 <= 35'(i_st.ay) * 35'(s);
            r_es2 <= 35'(i_st.az) * 35'(s);
            r_c1  <= c;
            r_sg  <= 20'sd65536 - 20'(c);

            r_t00 <= 51'(r_p00) * 51'(r_sg);
            r_t01 <= 51'(r_p01) * 51'(r_sg);
            r_t02 <= 51'(r_p02) * 51'(r_sg);
            r_t11 <= 51'(r_p11) * 51'(r_sg);
            r_t12 <= 51'(r_p12) * 51'(r_sg);
            r_t22 <= 51'(r_p22) * 51'(r_sg);
            r_f0  <= r_es0;
            r_f1  <= r_es1;
            r_f2  <= r_es2;
            r_c2  <= r_c1;

            r_c00 <= round_sat(56'(r_t00) + dg);
            r_c01 <= round_sat(56'(r_t01) + q2);
            r_c02 <= round_sat(56'(r_t02) - q1);
            r_c10 <= round_sat(56'(r_t01) - q2);
            r_c11 <= round_sat(56'(r_t11) + dg);
            r_c12 <= round_sat(56'(r_t12) + q0);
            r_c20 <= round_sat(56'(r_t02) + q1);
            r_c21 <= round_sat(56'(r_t12) - q0);
            r_c22 <= round_sat(56'(r_t22) + dg);
        end
    end

    assign o_valid = r_valid[2];
    assign o_c00 = r_c00;
    assign o_c01 = r_c01;
    assign o_c02 = r_c02;
    assign o_c10 = r_c10;
    assign o_c11 = r_c11;
    assign o_c12 = r_c12;
    assign o_c20 = r_c20;
    assign o_c21 = r_c21;
    assign o_c22 = r_c22;

endmodule

@@ rtl/core/axis_angle_to_rotation_matrix_core.sv @@
// Top level of the axis-angle to rotation matrix core.
// Instantiates aa2rm_cordic_cell and aa2rm_dcm; depends on aa2rm_pkg.
//
// Usage:
// The input channel takes an angle (Q3.13 radians) and a unit axis (Q1.14).
// The output channel returns the nine direction cosine entries in Q1.14.
// Both channels use valid and stall; a transaction completes when valid is
// high and stall is low.
// From input transaction to output valid, a transaction passes the quadrant fold
// register, the output register of each CORDIC cell, and the registers of the
// matrix stage, the last of which is the output register.
// Throughput is one transaction per cycle while not stalled; the pipeline is
// a row of CORDIC cells, each handing its state to the next every enabled cycle.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall is raised toward the sender; otherwise the block accepts every cycle.
// A synchronous reset clears all valid flags; no data is flushed out.
module axis_angle_to_rotation_matrix_core
    import aa2rm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_q14 i_angle,
    input  t_q14 i_axis_x,
    input  t_q14 i_axis_y,
    input  t_q14 i_axis_z,
    output logic o_valid,
    input  logic i_stall,
    output t_q14 o_c00,
    output t_q14 o_c01,
    output t_q14 o_c02,
    output t_q14 o_c10,
    output t_q14 o_c11,
    output t_q14 o_c12,
    output t_q14 o_c20,
    output t_q14 o_c21,
    output t_q14 o_c22
);

    logic en;
    logic signed [33:0] z34;
    logic signed [33:0] zf;
    t_cstate n_st0;
    t_cstate r_st0;
    logic r_valid0;
    t_cstate st [0:NSTG];
    logic vld [0:NSTG];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_comb begin
        z34   = {i_angle[15], i_angle, 17'b0};
        n_st0 = '0;
        zf    = z34;
        if (z34 > Q30_HALF_PI) begin
            zf        = z34 - Q30_PI;
            n_st0.neg = 1'b1;
        end else if (z34 < -Q30_HALF_PI) begin
            zf        = z34 + Q30_PI;
            n_st0.neg = 1'b1;
        end
        n_st0.x  = Q30_GAIN;
        n_st0.y  = '0;
        n_st0.z  = zf[32:0];
        n_st0.ax = i_axis_x;
        n_st0.ay = i_axis_y;
        n_st0.az = i_axis_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else if (en) begin
            r_valid0 <= i_valid;
        end
        if (en) begin
            r_st0 <= n_st0;
        end
    end

    assign st[0]  = r_st0;
    assign vld[0] = r_valid0;

    for (genvar k = 0; k < NSTG; k++) begin : g_cell
        aa2rm_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_shift (SHW'(k)),
            .i_atan  (atan_q30(k)),
            .i_valid (vld[k]),
            .i_st    (st[k]),
            .o_valid (vld[k+1]),
            .o_st    (st[k+1])
        );
    end

    aa2rm_dcm u_dcm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (vld[NSTG]),
        .i_st    (st[NSTG]),
        .o_valid (o_valid),
        .o_c00   (o_c00),
        .o_c01   (o_c01),
        .o_c02   (o_c02),
        .o_c10   (o_c10),
        .o_c11   (o_c11),
        .o_c12   (o_c12),
        .o_c20   (o_c20),
        .o_c21   (o_c21),
        .o_c22   (o_c22)
    );

endmodule
